// ----- hdl/hkbd_pkg.sv -----
// Package: shared constants and types for the header-keyed byte decryptor.
`timescale 1ns / 1ps

package hkbd_pkg;

    localparam int unsigned HEADER_LAST = 15;
    localparam int unsigned LEN_FIRST   = 12;

    localparam logic [3:0] HDR_LAST_IDX = 4'(HEADER_LAST);
    localparam logic [3:0] LEN_LAST_IDX = 4'(HEADER_LAST - 1);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_COPY    = 2'd1;
    localparam logic [1:0] PH_DECRYPT = 2'd2;
    localparam logic [1:0] PH_ERROR   = 2'd3;

    localparam logic [31:0] MAGIC_HEAD = 32'h69_66_6D_74;
    localparam logic [31:0] MAGIC_TAIL = 32'hFE_FE_FE_FE;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       err;
    } t_result;

    // Expected magic byte at a header position; only checked at 0..3 and 8..11
    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            4'd0:    b = MAGIC_HEAD[31:24];
            4'd1:    b = MAGIC_HEAD[23:16];
            4'd2:    b = MAGIC_HEAD[15:8];
            4'd3:    b = MAGIC_HEAD[7:0];
            4'd8:    b = MAGIC_TAIL[31:24];
            4'd9:    b = MAGIC_TAIL[23:16];
            4'd10:   b = MAGIC_TAIL[15:8];
            4'd11:   b = MAGIC_TAIL[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- hdl/header_keyed_byte_decryptor_unit.sv -----
// Top level: header-keyed byte decryptor with registered result and skid stage.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_byte) carries one file byte
//   per transfer. Output channel (o_out_valid / i_out_stall / o_out_byte,
//   o_is_error) carries zero or one result per input byte.
//   The first 16 bytes are the header and give no result, except that a bad
//   magic makes the 16th byte give an error result; from then on every byte
//   gives an error result with data zero.
//   After a good header, the plaintext-length bytes pass unchanged, then each
//   byte comes out as key minus byte.
//   A result is registered in the output stage, or in the skid register while the output is held.
//   Throughput: one byte per cycle while o_in_stall is low.
//   When the receiver stalls, one extra result is held in a skid register and
//   o_in_stall rises only once that register is occupied.
//   Reset (i_rst_n low, synchronous) empties the output stage and returns the
//   parser to the start of a header; each new file needs a reset.
`timescale 1ns / 1ps

module header_keyed_byte_decryptor_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_error
);
    import hkbd_pkg::*;

    t_result    new_res;
    logic       in_fire;
    logic       out_take;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_err;
    logic       r_skid_valid;
    logic [7:0] r_skid_data;
    logic       r_skid_err;

    assign o_in_stall = r_skid_valid;
    assign in_fire    = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    hkbd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_byte  (i_in_byte),
        .o_res   (new_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_out_err    <= r_skid_err;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= in_fire && new_res.valid;
            r_out_data  <= new_res.data;
            r_out_err   <= new_res.err;
        end else if (in_fire && new_res.valid) begin
            // output still held: park the new result
            r_skid_valid <= 1'b1;
            r_skid_data  <= new_res.data;
            r_skid_err   <= new_res.err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_data;
    assign o_is_error  = r_out_err;

endmodule

// ----- hdl/hkbd_core.sv -----
// Header parser and byte transform: stream state plus the result of the current byte.
`timescale 1ns / 1ps

module hkbd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    output hkbd_pkg::t_result    o_res
);
    import hkbd_pkg::*;

    logic [1:0]  r_phase,    n_phase;
    logic [3:0]  r_hdr_idx,  n_hdr_idx;
    logic        r_mismatch, n_mismatch;
    logic [23:0] r_copy_rem, n_copy_rem;
    logic [7:0]  r_key,      n_key;
    logic        is_magic_pos;
    logic [23:0] copy_dec;

    assign is_magic_pos = (r_hdr_idx < 4'd4) || (r_hdr_idx >= 4'd8 && r_hdr_idx < 4'd12);
    assign copy_dec     = r_copy_rem - 24'd1;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_mismatch = r_mismatch;
        n_copy_rem = r_copy_rem;
        n_key      = r_key;
        o_res      = '{valid: 1'b0, data: 8'h00, err: 1'b0};
        unique case (r_phase)
            PH_HEADER: begin
                if (is_magic_pos && i_byte != magic_byte(r_hdr_idx)) begin
                    n_mismatch = 1'b1;
                end
                // length bytes are little-endian at positions 12..14
                unique case (r_hdr_idx)
                    4'd12:   n_copy_rem = r_copy_rem | {16'h0000, i_byte};
                    4'd13:   n_copy_rem = r_copy_rem | {8'h00, i_byte, 8'h00};
                    LEN_LAST_IDX: n_copy_rem = r_copy_rem | {i_byte, 16'h0000};
                    default: n_copy_rem = r_copy_rem;
                endcase
                if (r_hdr_idx == HDR_LAST_IDX) begin
                    n_hdr_idx = 4'd0;
                    if (r_mismatch) begin
                        n_phase = PH_ERROR;
                        o_res   = '{valid: 1'b1, data: 8'h00, err: 1'b1};
                    end else begin
                        n_key   = i_byte - 8'd1;
                        n_phase = (r_copy_rem == 24'd0) ? PH_DECRYPT : PH_COPY;
                    end
                end else begin
                    n_hdr_idx = r_hdr_idx + 4'd1;
                end
            end
            PH_COPY: begin
                o_res      = '{valid: 1'b1, data: i_byte, err: 1'b0};
                n_copy_rem = copy_dec;
                if (copy_dec == 24'd0) begin
                    n_phase = PH_DECRYPT;
                end
            end
            PH_DECRYPT: begin
                o_res = '{valid: 1'b1, data: r_key - i_byte, err: 1'b0};
            end
            PH_ERROR: begin
                o_res = '{valid: 1'b1, data: 8'h00, err: 1'b1};
            end
            default: begin
                o_res = '{valid: 1'b1, data: 8'h00, err: 1'b1};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_idx  <= 4'd0;
            r_mismatch <= 1'b0;
            r_copy_rem <= 24'd0;
            r_key      <= 8'h00;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_mismatch <= n_mismatch;
            r_copy_rem <= n_copy_rem;
            r_key      <= n_key;
        end
    end

endmodule
